// ----- sv/lpht_pkg.sv -----
`timescale 1ns / 1ps
package lpht_pkg;

  localparam int BUCKETS = 1024;
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int HANDLE_W = 9;
  localparam int ENTRY_W = 1 + HANDLE_W + BKT_W + 16 + 4 * 64 + 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_SHIFT_RD,
    S_SHIFT_CHK,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] hash;
    logic [7:0]  flow_index;
    logic        side;
    logic [7:0]  protocol;
    logic [7:0]  iface;
    logic [63:0] our_addr_hi;
    logic [63:0] our_addr_lo;
    logic [63:0] end_addr_hi;
    logic [63:0] end_addr_lo;
    logic [15:0] our_port;
    logic [15:0] end_port;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_index;
    logic        found_side;
    logic [9:0]  bucket;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [BKT_W-1:0]    home;
    logic [15:0]         proto_iface;
    logic [63:0]         our_addr_hi;
    logic [63:0]         our_addr_lo;
    logic [63:0]         end_addr_hi;
    logic [63:0]         end_addr_lo;
    logic [31:0]         ports;
  } entry_t;

endpackage

// ----- sv/linear_probe_hash_table_unit.sv -----
`timescale 1ns / 1ps
// Channel   Ports                          Direction  Accepted when
// request   start, busy, in_req            in         start && !busy at clk
// result    out_valid, out_rsp             out        out_valid at clk (one cycle)
//
// Each probe step reads a bucket from the entry memory (S_PROBE_RD) and then checks its
// valid bit and contents (S_PROBE_CHK). A request probes bucket after bucket and then
// shows its result in S_DONE. A remove that finds its handle first runs the backward
// shift, reading and checking each bucket it scans, including the empty bucket that
// stops it, and then clears the final gap in S_CLEAR.
// Reset is synchronous and active low; a clearing pass over all BUCKETS entries follows
// it, with busy high, before the first request can be taken.
// The receiver cannot stall: each result shows for one cycle and busy stays high while it shows.
module linear_probe_hash_table_unit
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  // Entry store: synchronous memory with registered read data. Each entry carries
  // its own valid bit, so the whole bucket state lives in the memory.
  entry_t mem [BUCKETS];
  entry_t rd_r;

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  logic [BKT_W-1:0] b_r, b_nxt;      // probe bucket, later the gap; clear address
  logic [BKT_W-1:0] s_r, s_nxt;      // scan bucket during backward shift
  logic [BKT_W:0]   n_r, n_nxt;      // visit counter
  rsp_t rsp_r, rsp_nxt;

  logic             rd_en;
  logic [BKT_W-1:0] rd_addr;
  logic             wr_en;
  logic [BKT_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [HANDLE_W-1:0] req_handle;
  entry_t              req_entry;
  logic                key_match;
  logic [BKT_W-1:0]    dx, dh;

  assign req_handle = {req_r.flow_index, req_r.side};
  assign req_entry  = '{valid: 1'b1, handle: req_handle, home: req_r.hash[BKT_W-1:0],
                        proto_iface: {req_r.protocol, req_r.iface},
                        our_addr_hi: req_r.our_addr_hi, our_addr_lo: req_r.our_addr_lo,
                        end_addr_hi: req_r.end_addr_hi, end_addr_lo: req_r.end_addr_lo,
                        ports: {req_r.our_port, req_r.end_port}};
  assign key_match  = (rd_r.proto_iface == req_entry.proto_iface)
                   && (rd_r.our_addr_hi == req_r.our_addr_hi)
                   && (rd_r.our_addr_lo == req_r.our_addr_lo)
                   && (rd_r.end_addr_hi == req_r.end_addr_hi)
                   && (rd_r.end_addr_lo == req_r.end_addr_lo)
                   && (rd_r.ports == req_entry.ports);
  // Cyclic distances; BUCKETS is a power of two so wrap is free.
  assign dx = rd_r.home - s_r;
  assign dh = b_r - s_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      b_r     <= '0;
    end else begin
      state_r <= state_nxt;
      b_r     <= b_nxt;
    end
    req_r <= req_nxt;
    s_r   <= s_nxt;
    n_r   <= n_nxt;
    rsp_r <= rsp_nxt;
  end

  // Next state and datapath.
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    b_nxt     = b_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    rsp_nxt   = rsp_r;
    rd_en     = 1'b0;
    rd_addr   = b_r;
    wr_en     = 1'b0;
    wr_addr   = b_r;
    wr_data   = req_entry;
    unique case (state_r)
      S_INIT: begin
        // Clearing pass: one bucket per cycle is marked empty.
        wr_en   = 1'b1;
        wr_data = '0;
        b_nxt   = b_r + 1'b1;
        if (b_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          b_nxt     = in_req.hash[BKT_W-1:0];
          n_nxt     = '0;
          rsp_nxt   = '{status: ST_MISS, found_index: '0, found_side: 1'b0, bucket: '0};
          state_nxt = (op_t'(in_req.operation) == OP_NONE) ? S_DONE : S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        if (n_r == (BKT_W+1)'(BUCKETS)) begin
          if (op_t'(req_r.operation) == OP_INSERT) begin
            rsp_nxt.status = ST_FULL;
          end
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_PROBE_CHK;
        end
      end
      S_PROBE_CHK: begin
        if (!rd_r.valid) begin
          // Empty bucket ends every probe; insert claims it.
          if (op_t'(req_r.operation) == OP_INSERT) begin
            wr_en          = 1'b1;
            rsp_nxt.status = ST_DONE;
            rsp_nxt.bucket = 10'(b_r);
          end
          state_nxt = S_DONE;
        end else if (op_t'(req_r.operation) == OP_LOOKUP && key_match) begin
          rsp_nxt   = '{status: ST_DONE, found_index: rd_r.handle[HANDLE_W-1:1],
                        found_side: rd_r.handle[0], bucket: 10'(b_r)};
          state_nxt = S_DONE;
        end else if (op_t'(req_r.operation) == OP_INSERT && rd_r.handle == req_handle) begin
          wr_en          = 1'b1;
          rsp_nxt.status = ST_DONE;
          rsp_nxt.bucket = 10'(b_r);
          state_nxt      = S_DONE;
        end else if (op_t'(req_r.operation) == OP_REMOVE && rd_r.handle == req_handle) begin
          s_nxt     = b_r - 1'b1;
          n_nxt     = '0;
          state_nxt = S_SHIFT_RD;
        end else begin
          b_nxt     = b_r - 1'b1;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_PROBE_RD;
        end
      end
      S_SHIFT_RD: begin
        rd_addr = s_r;
        if (n_r == (BKT_W+1)'(BUCKETS - 1)) begin
          state_nxt = S_CLEAR;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_SHIFT_CHK;
        end
      end
      S_SHIFT_CHK: begin
        if (!rd_r.valid) begin
          // The cluster ends here.
          state_nxt = S_CLEAR;
        end else begin
          if (!(dx < dh)) begin
            // Entry may move up into the gap; the gap moves to its old place.
            wr_en   = 1'b1;
            wr_addr = b_r;
            wr_data = rd_r;
            b_nxt   = s_r;
          end
          s_nxt     = s_r - 1'b1;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_SHIFT_RD;
        end
      end
      S_CLEAR: begin
        wr_en          = 1'b1;
        wr_data        = '0;
        rsp_nxt.status = ST_DONE;
        rsp_nxt.bucket = 10'(b_r);
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    out_rsp   = rsp_r;
  end

endmodule

// ----- sv/lpht_checker.sv -----
`timescale 1ns / 1ps
module lpht_checker
  import lpht_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input rsp_t out_rsp
);

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without active request");
  a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy stays after result");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");
  a_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ST_DONE) |-> (out_rsp.bucket == '0
      && out_rsp.found_index == '0)) else $error("fields not zero on miss");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_rsp(out_rsp)
);

// ----- tb/linear_probe_hash_table_unit_test.sv -----
`timescale 1ns / 1ps
module linear_probe_hash_table_unit_test;
  import lpht_pkg::*;

  // Shadow copy of the flow table, updated as each request is accepted.
  class flow_table_scoreboard;
    bit          live[BUCKETS];
    bit [8:0]    owner[BUCKETS];
    bit [9:0]    home_of[BUCKETS];
    bit [15:0]   pi_of[BUCKETS];
    bit [255:0]  addr_of[BUCKETS];
    bit [31:0]   ports_of[BUCKETS];
    rsp_t        pending[$];
    int          errors;

    function bit [9:0] down(bit [9:0] b);
      return (b == 0) ? 10'(BUCKETS - 1) : b - 10'd1;
    endfunction

    // True when x lies in the cyclic range [lo, hi).
    function bit between(bit [9:0] x, bit [9:0] lo, bit [9:0] hi);
      bit [9:0] dx, dh;
      dx = x - lo;
      dh = hi - lo;
      return dx < dh;
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      bit [9:0]    b, s;
      bit [8:0]    h;
      bit [255:0]  a;
      bit          hit;
      int          n;
      e = '0;
      e.status = ST_MISS;
      b = r.hash[9:0];
      h = {r.flow_index, r.side};
      a = {r.our_addr_hi, r.our_addr_lo, r.end_addr_hi, r.end_addr_lo};
      hit = 0;
      case (r.operation)
        OP_LOOKUP: begin
          for (n = 0; n < BUCKETS && live[b]; n++) begin
            if (pi_of[b] == {r.protocol, r.iface} && addr_of[b] == a &&
                ports_of[b] == {r.our_port, r.end_port}) begin
              hit = 1;
              break;
            end
            b = down(b);
          end
          if (hit) begin
            e.status = ST_DONE;
            {e.found_index, e.found_side} = owner[b];
            e.bucket = b;
          end
        end
        OP_INSERT: begin
          for (n = 0; n < BUCKETS; n++) begin
            if (!live[b] || owner[b] == h) begin
              hit = 1;
              break;
            end
            b = down(b);
          end
          if (hit) begin
            live[b] = 1;
            owner[b] = h;
            home_of[b] = r.hash[9:0];
            pi_of[b] = {r.protocol, r.iface};
            addr_of[b] = a;
            ports_of[b] = {r.our_port, r.end_port};
            e.status = ST_DONE;
            e.bucket = b;
          end else begin
            e.status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          for (n = 0; n < BUCKETS && live[b]; n++) begin
            if (owner[b] == h) begin
              hit = 1;
              break;
            end
            b = down(b);
          end
          if (hit) begin
            // Backward shift: pull up every entry whose home is not
            // between its bucket and the gap.
            s = down(b);
            for (n = 0; n + 1 < BUCKETS && live[s]; n++) begin
              if (!between(home_of[s], s, b)) begin
                live[b] = live[s];
                owner[b] = owner[s];
                home_of[b] = home_of[s];
                pi_of[b] = pi_of[s];
                addr_of[b] = addr_of[s];
                ports_of[b] = ports_of[s];
                b = s;
              end
              s = down(s);
            end
            live[b] = 0;
            e.status = ST_DONE;
            e.bucket = b;
          end
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      if (got.found_index !== e.found_index)
        $display("%0t: found_index expected %0d actual %0d", $time, e.found_index,
                 got.found_index);
      if (got.found_side !== e.found_side)
        $display("%0t: found_side expected %0d actual %0d", $time, e.found_side,
                 got.found_side);
      if (got.bucket !== e.bucket)
        $display("%0t: bucket expected %0d actual %0d", $time, e.bucket, got.bucket);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  rsp_t out_rsp;

  linear_probe_hash_table_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  flow_table_scoreboard flow_sb = new();
  int quiet_cycles = 0;
  // The quiet limit covers a full-table probe plus a full cluster scan.
  localparam int QUIET_LIMIT = 20 * BUCKETS;

  // Pool of connection keys, reused so that lookups hit and clusters form.
  req_t keys[32];
  bit   gaps_on = 1;

  // Results cannot be held off, so every strobe is checked at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) flow_sb.check_result(out_rsp);
    if (rst_n && ((start && !busy) || out_valid)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(req_t r);
    int k;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 9);
      repeat (k) @(posedge clk);
    end
    start <= 1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    flow_sb.note_request(r);
    start <= 0;
    // The block stays busy for at least this cycle, so nothing is lost here.
    @(posedge clk);
  endtask

  function automatic req_t random_key();
    req_t r;
    r.operation = OP_LOOKUP;
    r.hash = {$urandom, $urandom};
    r.flow_index = 8'($urandom);
    r.side = 1'($urandom);
    r.protocol = 8'($urandom);
    r.iface = 8'($urandom);
    r.our_addr_hi = {$urandom, $urandom};
    r.our_addr_lo = {$urandom, $urandom};
    r.end_addr_hi = {$urandom, $urandom};
    r.end_addr_lo = {$urandom, $urandom};
    r.our_port = 16'($urandom);
    r.end_port = 16'($urandom);
    return r;
  endfunction

  // Build a request on a pooled key; a narrow hash spread packs clusters.
  function automatic req_t pooled(op_t op);
    req_t r;
    r = keys[$urandom_range(0, 31)];
    r.operation = op;
    return r;
  endfunction

  task automatic drain();
    while (flow_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    req_t r;
    int i, j;
    for (i = 0; i < 32; i++) begin
      keys[i] = random_key();
      keys[i].hash[9:0] = 10'($urandom_range(0, 5)) - 10'd2;
      keys[i].flow_index = 8'(i / 2);
      keys[i].side = 1'(i % 2);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: miss on an empty table, inserts at the wrap bucket,
    // reinsert of a present handle, lookups, removes with shifts,
    // a redundant remove, the unused opcode, and all-ones and all-zero fields.
    r = keys[0]; r.operation = OP_LOOKUP; send_request(r);
    r = keys[0]; r.operation = OP_REMOVE; send_request(r);
    for (i = 0; i < 6; i++) begin
      r = keys[i]; r.operation = OP_INSERT; r.hash = 64'd0; send_request(r);
    end
    r = keys[2]; r.operation = OP_INSERT; r.hash = '1; send_request(r);
    r = keys[3]; r.operation = OP_LOOKUP; r.hash = 64'd0; send_request(r);
    r = keys[1]; r.operation = OP_REMOVE; r.hash = 64'd0; send_request(r);
    r = keys[4]; r.operation = OP_LOOKUP; r.hash = 64'd0; send_request(r);
    r = keys[1]; r.operation = OP_REMOVE; r.hash = 64'd0; send_request(r);
    r = '1; r.operation = OP_INSERT; send_request(r);
    r = '1; r.operation = OP_LOOKUP; send_request(r);
    r = '1; r.operation = OP_NONE; send_request(r);
    r = '1; r.operation = OP_REMOVE; send_request(r);
    r = '0; r.operation = OP_INSERT; send_request(r);
    r = '0; r.operation = OP_LOOKUP; send_request(r);
    r = '0; r.operation = OP_REMOVE; send_request(r);
    drain();

    // Random: mostly pooled keys on crowded home buckets, some noise.
    for (i = 0; i < 600; i++) begin
      if (i == 300) drain();
      if (i >= 520) gaps_on = 0;
      j = $urandom_range(0, 9);
      if (j < 4) r = pooled(OP_INSERT);
      else if (j < 7) r = pooled(OP_LOOKUP);
      else if (j < 9) r = pooled(OP_REMOVE);
      else begin
        r = random_key();
        r.operation = op_t'($urandom_range(0, 3));
      end
      send_request(r);
    end

    // Load a band of buckets through fresh keys, then miss on random keys.
    for (i = 0; i < 80; i++) begin
      r = random_key();
      r.operation = OP_INSERT;
      r.flow_index = i[8:1];
      r.side = i[0];
      r.hash[9:0] = i[9:0];
      send_request(r);
    end
    r = random_key(); r.operation = OP_LOOKUP; send_request(r);
    r = random_key(); r.operation = OP_REMOVE; r.flow_index = 8'hA5; send_request(r);

    while (flow_sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (flow_sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
